// ----- rtl/assert_macros.svh -----
// Assertion helpers for the list store checker.
// Both sample on clk_i; the first is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset.
`define ILST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ILST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/ilst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ilst_pkg;

  // Store geometry
  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned SLOT_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // Beat field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_LINK_A,
    S_LINK_B,
    S_DATA_RD,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] data_out;
    logic [LEN_W-1:0]  length;
    logic              empty_res;
  } out_item_t;

  // Link memory access for one cycle
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
    logic              clear;
  } link_req_t;

  // Data memory access for one cycle
  typedef struct packed {
    logic                  we;
    logic [SLOT_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [SLOT_W-1:0]     raddr;
  } data_req_t;

endpackage

`default_nettype wire

// ----- rtl/ilst_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/ilst_link_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilst_link_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ilst_pkg::link_req_t       req_i,
  output logic [ilst_pkg::SLOT_W-1:0] rdata_o
);

  import ilst_pkg::*;

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic                rvalid_q, rvalid_d;
  logic [SLOT_W-1:0]   raddr_q;
  logic [SLOT_W-1:0]   ram_rdata;
  logic [SLOT_W-1:0]   dflt_link;

  ilst_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  // Mark written entries; clear drops every entry back to the free chain
  always_comb begin
    valid_d = valid_q;
    if (req_i.clear) begin
      valid_d = '0;
    end else if (req_i.we) begin
      valid_d[req_i.waddr] = 1'b1;
    end
  end

  assign rvalid_d = valid_q[req_i.raddr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      rvalid_q <= rvalid_d;
    end
  end

  // Hold the read address for the untouched-entry default
  always_ff @(posedge clk_i) begin
    raddr_q <= req_i.raddr;
  end

  // Untouched entry links to the next slot, the last one back to slot zero
  assign dflt_link = (raddr_q == SLOT_W'(CAPACITY - 1)) ? '0 : raddr_q + 1'b1;
  assign rdata_o   = rvalid_q ? ram_rdata : dflt_link;

endmodule

`default_nettype wire

// ----- rtl/ilst_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilst_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  ilst_pkg::in_item_t            in_item_i,
  output logic                          in_stall_o,
  output ilst_pkg::link_req_t           link_req_o,
  input  logic [ilst_pkg::SLOT_W-1:0]   link_rdata_i,
  output ilst_pkg::data_req_t           data_req_o,
  input  logic [ilst_pkg::DATA_WIDTH-1:0] data_rdata_i,
  output logic                          res_valid_o,
  output ilst_pkg::out_item_t           res_item_o,
  input  logic                          res_take_i
);

  import ilst_pkg::*;

  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  state_e                state_q, state_d;
  logic [CMD_W-1:0]      op_q, op_d;
  logic                  pos_zero_q, pos_zero_d;
  logic [SLOT_W-1:0]     steps_q, steps_d;
  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [SLOT_W-1:0]     prev_q, prev_d;
  logic [SLOT_W-1:0]     nxt_q, nxt_d;
  logic [SLOT_W-1:0]     ns_q, ns_d;
  logic [SLOT_W-1:0]     first_q, first_d;
  logic [SLOT_W-1:0]     free_q, free_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [STAT_W-1:0]     status_q, status_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;

  logic              accept;
  logic              is_ins;
  logic              is_walk;
  logic              op_ins;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  eff_pos;
  logic [STAT_W-1:0] chk_status;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign is_ins  = (in_item_i.cmd == CMD_APPEND) || (in_item_i.cmd == CMD_INSERT);
  assign is_walk = (in_item_i.cmd == CMD_REMOVE) || (in_item_i.cmd == CMD_READ);
  assign op_ins  = (op_q == CMD_APPEND) || (op_q == CMD_INSERT);
  assign cnt_ext = CMP_W'(count_q);
  assign eff_pos = (in_item_i.cmd == CMD_APPEND) ? cnt_ext : CMP_W'(in_item_i.position);

  // Range and capacity check on the incoming beat
  always_comb begin
    chk_status = ST_DONE;
    if (is_ins) begin
      if (eff_pos > cnt_ext) begin
        chk_status = ST_BAD_INDEX;
      end else if (cnt_ext == CMP_W'(CAPACITY)) begin
        chk_status = ST_FULL;
      end
    end else if (is_walk) begin
      if (eff_pos >= cnt_ext) begin
        chk_status = ST_BAD_INDEX;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (chk_status != ST_DONE) begin
            state_d = S_RESULT;
          end else if (is_ins) begin
            state_d = S_POP;
          end else if (is_walk) begin
            state_d = S_WALK;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_POP: begin
        state_d = pos_zero_q ? S_LINK_A : S_WALK;
      end
      S_WALK: begin
        if (steps_q == '0) begin
          state_d = (op_q == CMD_READ) ? S_DATA_RD : S_LINK_A;
        end
      end
      S_LINK_A:  state_d = S_LINK_B;
      S_LINK_B:  state_d = S_RESULT;
      S_DATA_RD: state_d = S_RESULT;
      S_RESULT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory accesses per state
  always_comb begin
    op_d       = op_q;
    pos_zero_d = pos_zero_q;
    steps_d    = steps_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    nxt_d      = nxt_q;
    ns_d       = ns_q;
    first_d    = first_q;
    free_d     = free_q;
    count_d    = count_q;
    status_d   = status_q;
    word_d     = word_q;
    link_req_o = '0;
    data_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d       = in_item_i.cmd;
          status_d   = chk_status;
          word_d     = DATA_WIDTH'(in_item_i.data_in);
          pos_zero_d = (eff_pos == '0);
          steps_d    = is_ins ? SLOT_W'(eff_pos - 1'b1) : SLOT_W'(eff_pos);
          if (chk_status == ST_DONE) begin
            if (in_item_i.cmd == CMD_CLEAR) begin
              link_req_o.clear = 1'b1;
              first_d          = '0;
              free_d           = '0;
              count_d          = '0;
            end else if (is_ins) begin
              // fetch the link of the free head
              link_req_o.raddr = free_q;
            end else if (is_walk) begin
              link_req_o.raddr = first_q;
              cur_d            = first_q;
            end
          end
        end
      end
      S_POP: begin
        // take the free head as the new slot and store the word
        ns_d             = free_q;
        free_d           = link_rdata_i;
        data_req_o.we    = 1'b1;
        data_req_o.waddr = free_q;
        data_req_o.wdata = word_q;
        if (pos_zero_q) begin
          nxt_d = first_q;
        end else begin
          link_req_o.raddr = first_q;
          cur_d            = first_q;
        end
      end
      S_WALK: begin
        // one list step per cycle, address straight from the read data
        if (steps_q == '0) begin
          nxt_d            = link_rdata_i;
          data_req_o.raddr = cur_q;
        end else begin
          prev_d           = cur_q;
          cur_d            = link_rdata_i;
          steps_d          = steps_q - 1'b1;
          link_req_o.raddr = link_rdata_i;
        end
      end
      S_LINK_A: begin
        if (op_ins) begin
          link_req_o.we    = 1'b1;
          link_req_o.waddr = ns_q;
          link_req_o.wdata = nxt_q;
        end else if (pos_zero_q) begin
          first_d = nxt_q;
        end else begin
          link_req_o.we    = 1'b1;
          link_req_o.waddr = prev_q;
          link_req_o.wdata = nxt_q;
        end
      end
      S_LINK_B: begin
        if (op_ins) begin
          if (pos_zero_q) begin
            first_d = ns_q;
          end else begin
            link_req_o.we    = 1'b1;
            link_req_o.waddr = cur_q;
            link_req_o.wdata = ns_q;
          end
          count_d = count_q + 1'b1;
        end else begin
          // return the removed slot to the free chain
          link_req_o.we    = 1'b1;
          link_req_o.waddr = cur_q;
          link_req_o.wdata = free_q;
          free_d           = cur_q;
          count_d          = count_q - 1'b1;
        end
      end
      S_DATA_RD: begin
        word_d = data_rdata_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= '0;
      free_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      free_q  <= free_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_zero_q <= pos_zero_d;
    steps_q    <= steps_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    nxt_q      <= nxt_d;
    ns_q       <= ns_d;
    status_q   <= status_d;
    word_q     <= word_d;
  end

  // Result beat
  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);

  always_comb begin
    res_item_o          = '0;
    res_item_o.status   = status_q;
    res_item_o.length   = LEN_W'(count_q);
    res_item_o.empty_res = (count_q == '0);
    if ((op_q == CMD_READ) && (status_q == ST_DONE)) begin
      res_item_o.data_out = WORD_W'(word_q);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/indexed_list_store_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake             Beat
// in       input      in_valid_i/in_stall_o   in_item_t (cmd, position, data_in)
// out      output     out_valid_o/out_stall_i out_item_t (status, data_out, length, empty_res)
//
// One request at a time, one list step per cycle on the link memory read port.
// Accept to result beat: insert at position p pops a free slot, walks the list to p
// and relinks (append walks to the tail, p = length), remove walks and relinks, read
// walks and reads the word; clear, spare codes and rejected requests go straight to the result.
// Reset clears the link state at once through per-entry valid bits; no sweep.
// A result stalled in the output register lets the next request run; that
// request's result then waits in the control until the register drains.

module indexed_list_store_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ilst_pkg::in_item_t  in_item_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output ilst_pkg::out_item_t out_item_o,
  input  logic                out_stall_i
);

  import ilst_pkg::*;

  link_req_t             link_req;
  logic [SLOT_W-1:0]     link_rdata;
  data_req_t             data_req;
  logic [DATA_WIDTH-1:0] data_rdata;
  logic                  res_valid;
  out_item_t             res_item;
  logic                  res_take;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  ilst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata),
    .data_req_o   (data_req),
    .data_rdata_i (data_rdata),
    .res_valid_o  (res_valid),
    .res_item_o   (res_item),
    .res_take_i   (res_take)
  );

  ilst_link_mem u_link_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  ilst_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_req.we),
    .waddr_i (data_req.waddr),
    .wdata_i (data_req.wdata),
    .raddr_i (data_req.raddr),
    .rdata_o (data_rdata)
  );

  // Output register: load when empty or draining
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_item_d  = res_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- rtl/ilst_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input ilst_pkg::in_item_t  in_item_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input ilst_pkg::out_item_t out_item_o,
  input logic                out_stall_i
);

  import ilst_pkg::*;

  `include "assert_macros.svh"

  // A stalled result beat holds
  `ILST_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "result beat changed under stall")

  // One request in flight: an accept closes the input for the next cycle
  `ILST_ASSERT(a_one_in_flight, in_valid_i && !in_stall_o |=> in_stall_o, "input open right after accept")

  // Empty flag agrees with the length
  `ILST_ASSERT(a_empty_flag, out_valid_o |-> (out_item_o.empty_res == (out_item_o.length == '0)), "empty flag disagrees with length")

  // Only a completed read carries a word
  `ILST_ASSERT(a_data_zero, out_valid_o && (out_item_o.status != ST_DONE) |-> (out_item_o.data_out == '0), "failed request returned data")

  // No result beat right after reset
  `ILST_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o, "result beat during reset")

endmodule

bind indexed_list_store_core ilst_checker u_ilst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_item_i   (in_item_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_item_o  (out_item_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
